// ===== sv/interpolating_lookup_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the interpolating lookup table unit
// Shorthand for clocked assertions, reset disabled, sampled on clk and rst.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_LOOKUP_TABLE_UNIT_MACROS_SVH
`define INTERPOLATING_LOOKUP_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define ILUT_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("interpolating lookup table: same-cycle check failed");

// Next-cycle implication.
`define ILUT_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("interpolating lookup table: next-cycle check failed");

`endif

// ===== sv/ilut_pkg.sv =====
// ----------------------------------------------------------------------------
// ilut_pkg
// Widths and codes shared by the interpolating lookup table unit.
// ----------------------------------------------------------------------------
package ilut_pkg;

  localparam int KEY_W      = 16;
  localparam int VALUE_W    = 32;
  localparam int ENTRY_W    = KEY_W + VALUE_W;
  // |(vh - vl) * (q - kl)| stays below 2**48
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 16;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  typedef enum logic [1:0] {
    REGION_BELOW  = 2'd0,
    REGION_EXACT  = 2'd1,
    REGION_INTERP = 2'd2,
    REGION_ABOVE  = 2'd3
  } region_t;

endpackage

// ===== sv/interpolating_lookup_table_unit.sv =====
// ----------------------------------------------------------------------------
// interpolating_lookup_table_unit
// Piecewise-linear lookup over a table of breakpoints in one block RAM.
// ----------------------------------------------------------------------------
// A write beat (mode 0) stores one key/value breakpoint.
// A query beat (mode 1) scans the table from entry 0, one RAM read per cycle,
// up to the first key not below the query key, and returns the first value,
// the exact-match value, the last value, or a linear interpolation between
// the two neighbors truncated toward zero, together with a region code.
// The scan is paced by the single RAM read port, the interpolation by a
// 49-step serial divider. The result sits in an output register, so the
// next item is taken while it waits.

module interpolating_lookup_table_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [5:0]         entry_index,
  input  logic signed [15:0] key,
  input  logic signed [31:0] entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]         region
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = (CW > 7) ? CW : 7;
  localparam int IW = (AW > 6) ? AW : 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_RESP
  } state_t;

  state_t state;

  logic [6:0]                             entry_count;
  logic [ilut_pkg::ENTRY_W-1:0]           mem [MAX_ENTRIES];
  logic [ilut_pkg::ENTRY_W-1:0]           rdata;

  logic [NW-1:0]                          cnt_ext;
  logic [NW-1:0]                          n_active;
  logic [IW-1:0]                          widx;
  logic                                   wr_en;
  logic                                   issue;

  logic [NW-1:0]                          rd_idx;
  logic [NW-1:0]                          didx;
  logic                                   dv;
  logic signed [15:0]                     q;
  logic signed [15:0]                     kl;
  logic signed [31:0]                     vl;
  logic signed [15:0]                     rkey;
  logic signed [31:0]                     rval;

  logic signed [32:0]                     diff_v;
  logic signed [16:0]                     dq;
  logic [ilut_pkg::DIVISOR_W-1:0]         den;
  logic signed [49:0]                     prod;
  logic [49:0]                            mag;
  logic                                   neg;
  logic [ilut_pkg::DIVIDEND_W-1:0]        dividend;
  logic                                   div_go;
  logic                                   div_done;
  logic [ilut_pkg::DIVIDEND_W-1:0]        quot;
  logic signed [32:0]                     q_signed;
  logic signed [32:0]                     interp_sum;

  logic signed [31:0]                     res;
  ilut_pkg::region_t                      res_region;

  // active count, clamped to 1..MAX_ENTRIES
  always_comb begin
    cnt_ext = NW'(entry_count);
    if (cnt_ext == '0) begin
      n_active = NW'(1);
    end else if (cnt_ext > NW'(MAX_ENTRIES)) begin
      n_active = NW'(MAX_ENTRIES);
    end else begin
      n_active = cnt_ext;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign widx     = IW'(entry_index);
  assign wr_en    = in_valid && in_ready && !mode && (32'(entry_index) < MAX_ENTRIES);
  assign issue    = (state == ST_SCAN) && (rd_idx < n_active);

  assign rkey = $signed(rdata[ilut_pkg::ENTRY_W-1:ilut_pkg::VALUE_W]);
  assign rval = $signed(rdata[ilut_pkg::VALUE_W-1:0]);

  assign mag        = prod[49] ? 50'(-prod) : 50'(prod);
  assign q_signed   = $signed(quot[32:0]);
  assign interp_sum = {vl[31], vl} + (neg ? -q_signed : q_signed);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 7'd1;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx[AW-1:0]] <= {key, entry_value};
    end
    if (issue) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

  ilut_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      dv        <= 1'b0;
      div_go    <= 1'b0;
    end else begin
      // pulse the divider start in the cycle after the operands are set up
      div_go <= (state == ST_DSTART);
      if (out_valid && out_ready && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && mode) begin
            q      <= key;
            rd_idx <= '0;
            dv     <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          dv   <= issue;
          didx <= rd_idx;
          if (dv) begin
            if (rkey >= q) begin
              if (didx == '0) begin
                res        <= rval;
                res_region <= ilut_pkg::REGION_BELOW;
                state      <= ST_RESP;
              end else if (rkey == q) begin
                res        <= rval;
                res_region <= ilut_pkg::REGION_EXACT;
                state      <= ST_RESP;
              end else begin
                diff_v <= {rval[31], rval} - {vl[31], vl};
                dq     <= {q[15], q} - {kl[15], kl};
                den    <= 16'({rkey[15], rkey} - {kl[15], kl});
                state  <= ST_MUL;
              end
            end else begin
              // key still below the query: remember it as the lower neighbor
              kl <= rkey;
              vl <= rval;
              if (didx == n_active - NW'(1)) begin
                res        <= rval;
                res_region <= ilut_pkg::REGION_ABOVE;
                state      <= ST_RESP;
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= diff_v * dq;
          state <= ST_DSTART;
        end
        ST_DSTART: begin
          // divide the magnitude, restore the sign after
          neg      <= prod[49];
          dividend <= mag[ilut_pkg::DIVIDEND_W-1:0];
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res        <= interp_sum[31:0];
            res_region <= ilut_pkg::REGION_INTERP;
            state      <= ST_RESP;
          end
        end
        ST_RESP: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_value <= res;
            region       <= res_region;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ilut_div.sv =====
// ----------------------------------------------------------------------------
// ilut_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilut_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ilut_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [ilut_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [ilut_pkg::DIVIDEND_W-1:0]  quotient
);

  logic [ilut_pkg::DIVIDEND_W-1:0] acc;
  logic [ilut_pkg::DIVISOR_W-1:0]  rem;
  logic [ilut_pkg::DIVISOR_W-1:0]  dsr;
  logic [ilut_pkg::STEP_W-1:0]     steps;
  logic                            busy;
  logic [ilut_pkg::DIVISOR_W:0]    trial;
  logic [ilut_pkg::DIVISOR_W:0]    diff;
  logic                            fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, acc[ilut_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (steps == '0);
      if (start) begin
        acc   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
        steps <= ilut_pkg::STEP_W'(ilut_pkg::DIVIDEND_W - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        acc <= {acc[ilut_pkg::DIVIDEND_W-2:0], fits};
        rem <= fits ? diff[ilut_pkg::DIVISOR_W-1:0] : trial[ilut_pkg::DIVISOR_W-1:0];
        if (steps == '0) begin
          busy <= 1'b0;
        end else begin
          steps <= steps - 1'b1;
        end
      end
    end
  end

  assign quotient = acc;

endmodule

// ===== sv/ilut_checker.sv =====
// ----------------------------------------------------------------------------
// ilut_checker
// Port-level checks on the interpolating lookup table unit, bound to the top.
// ----------------------------------------------------------------------------
`include "interpolating_lookup_table_unit_macros.svh"

module ilut_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_write,
  input logic [6:0]         cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic               mode,
  input logic [5:0]         entry_index,
  input logic signed [15:0] key,
  input logic signed [31:0] entry_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] result_value,
  input logic [1:0]         region
);

  // a stalled result beat holds
  `ILUT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(region))

  // a query occupies the block
  `ILUT_ASSERT_NEXT(a_query_busy, in_valid && in_ready && mode, !in_ready)

  // a write leaves the block ready for the next beat
  `ILUT_ASSERT_NEXT(a_write_ready, in_valid && in_ready && !mode, in_ready)

  // a new result only appears at the end of a query
  `ILUT_ASSERT_IMP(a_result_source, $rose(out_valid), !$past(in_ready))

endmodule

bind interpolating_lookup_table_unit ilut_checker u_ilut_checker (.*);
